FILE: design/sgms_pkg.sv
package sgms_pkg;

	// field widths
	localparam int unsigned LenW  = 20;
	localparam int unsigned TickW = 16;
	localparam int unsigned JogW  = 13;
	localparam int unsigned PosW  = 32;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 20;

	// reset values of the configuration registers, and the tick counter maximum
	localparam logic [TickW-1:0] ReturnScanTicksRst = 16'd5000;
	localparam logic signed [JogW-1:0] JogSpeedRst = -13'sd1000;
	localparam logic [TickW-1:0] TickMax = '1;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_HOME_OFFSET       = 3'd0,
		REG_GAP_LENGTH        = 3'd1,
		REG_SCAN_LENGTH       = 3'd2,
		REG_RETURN_SCAN_TICKS = 3'd3,
		REG_JOG_SPEED         = 3'd4
	} reg_idx_t;

	// motor command codes
	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_JOG  = 2'd1,
		CMD_STOP = 2'd2,
		CMD_MOVE = 2'd3
	} cmd_t;

	// zone codes
	typedef enum logic [1:0] {
		Z_FIRST  = 2'd0,
		Z_SCAN   = 2'd1,
		Z_GAP    = 2'd2,
		Z_RETURN = 2'd3
	} zone_t;

endpackage

FILE: design/scan_gantry_motion_sequencer_core.sv
// Scan gantry motion sequencer.
//
// Input channel (in_valid / in_stall) carries one control tick: home and
// start sensor levels, the start request and the stepper position. Output
// channel (out_valid / out_stall) returns one transaction per tick: motor
// command, target position, scanner enable and zone.
// Configuration goes through cfg_wr_en / cfg_index / cfg_data, taken on any
// clock edge with cfg_wr_en high; write it only while the block is idle.
//
// A transaction passes one input register, then the sequencing logic into
// the output register. One tick is accepted every cycle while in_stall is
// low; the throughput is set by the single update of the sequencer state
// per tick.
// While the receiver stalls, the output register holds its transaction,
// the input register holds the next tick and in_stall rises once both
// are full. Reset clears both registers, the sequencer state and restores
// the configuration defaults; the block then jogs toward home.
module scan_gantry_motion_sequencer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [sgms_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [sgms_pkg::CfgDataW-1:0]        cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 home_sensor,
	input  logic                                 start_sensor,
	input  logic                                 start_request,
	input  logic signed [sgms_pkg::PosW-1:0]     motor_position,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           motor_command,
	output logic signed [sgms_pkg::PosW-1:0]     target_position,
	output logic                                 scanner_enable,
	output logic [1:0]                           zone
);

	// configuration registers
	logic [sgms_pkg::LenW-1:0]         home_offset_q;
	logic [sgms_pkg::LenW-1:0]         gap_length_q;
	logic [sgms_pkg::LenW-1:0]         scan_length_q;
	logic [sgms_pkg::TickW-1:0]        return_scan_ticks_q;
	logic signed [sgms_pkg::JogW-1:0]  jog_speed_q;

	// sequencer state
	logic                          homed_q;
	logic                          run_q;
	logic [sgms_pkg::PosW-1:0]     home_pos_q;
	logic [sgms_pkg::PosW-1:0]     leg_start_q;
	sgms_pkg::zone_t               zone_q;
	logic [sgms_pkg::TickW-1:0]    ret_ticks_q;
	logic                          scan_lvl_q;

	// input stage
	logic                          v_s1;
	logic                          home_s1;
	logic                          start_s1;
	logic                          req_s1;
	logic [sgms_pkg::PosW-1:0]     pos_s1;

	// output stage
	logic                          out_v_q;
	sgms_pkg::cmd_t                cmd_q;
	logic [sgms_pkg::PosW-1:0]     target_q;
	logic                          scan_en_q;
	sgms_pkg::zone_t               zone_out_q;

	logic out_free;
	logic advance;
	logic in_accept;

	// next-state values
	logic                          homed_n;
	logic                          run_n;
	logic [sgms_pkg::PosW-1:0]     home_pos_n;
	logic [sgms_pkg::PosW-1:0]     leg_start_n;
	sgms_pkg::zone_t               zone_n;
	sgms_pkg::zone_t               zone_eff;
	logic [sgms_pkg::TickW-1:0]    ret_ticks_n;
	logic                          scan_lvl_n;
	sgms_pkg::cmd_t                cmd_n;
	logic [sgms_pkg::PosW-1:0]     target_n;
	sgms_pkg::zone_t               zone_out_n;
	logic                          start_eff;
	logic                          active;
	logic                          at_target;

	// handshake
	assign out_free  = !out_v_q || !out_stall;
	assign advance   = v_s1 && out_free;
	assign in_stall  = v_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	// write configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_offset_q       <= '0;
			gap_length_q        <= '0;
			scan_length_q       <= '0;
			return_scan_ticks_q <= sgms_pkg::ReturnScanTicksRst;
			jog_speed_q         <= sgms_pkg::JogSpeedRst;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sgms_pkg::REG_HOME_OFFSET:       home_offset_q <= cfg_data;
				sgms_pkg::REG_GAP_LENGTH:        gap_length_q <= cfg_data;
				sgms_pkg::REG_SCAN_LENGTH:       scan_length_q <= cfg_data;
				sgms_pkg::REG_RETURN_SCAN_TICKS:
					return_scan_ticks_q <= cfg_data[sgms_pkg::TickW-1:0];
				sgms_pkg::REG_JOG_SPEED:
					jog_speed_q <= signed'(cfg_data[sgms_pkg::JogW-1:0]);
				default: ;
			endcase
		end
	end

	// capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			home_s1  <= home_sensor;
			start_s1 <= start_sensor;
			req_s1   <= start_request;
			pos_s1   <= motor_position;
		end
	end

	// sequencing logic for one tick
	always_comb begin
		start_eff   = !home_s1 && start_s1;
		homed_n     = homed_q || home_s1;
		home_pos_n  = (!homed_q && home_s1) ? pos_s1 : home_pos_q;
		run_n       = run_q;
		leg_start_n = leg_start_q;
		zone_n      = zone_q;
		ret_ticks_n = ret_ticks_q;
		scan_lvl_n  = scan_lvl_q;
		target_n    = '0;
		at_target   = 1'b0;

		// seek home until the sensor fires
		if (!homed_q) begin
			cmd_n = home_s1 ? sgms_pkg::CMD_STOP : sgms_pkg::CMD_JOG;
		end else begin
			cmd_n = sgms_pkg::CMD_HOLD;
		end

		active   = homed_n && (req_s1 || run_q);
		zone_eff = start_eff ? sgms_pkg::Z_RETURN : zone_q;

		if (active) begin
			run_n  = 1'b1;
			zone_n = zone_eff;
			cmd_n  = sgms_pkg::CMD_MOVE;
			case (zone_eff)
				sgms_pkg::Z_FIRST: begin
					target_n  = home_pos_n + {{(sgms_pkg::PosW-sgms_pkg::LenW){1'b0}},
						home_offset_q};
					at_target = (pos_s1 == target_n);
					if (at_target) begin
						zone_n      = sgms_pkg::Z_SCAN;
						leg_start_n = pos_s1;
					end
				end
				sgms_pkg::Z_SCAN: begin
					target_n  = leg_start_q + {{(sgms_pkg::PosW-sgms_pkg::LenW){1'b0}},
						scan_length_q};
					at_target = (pos_s1 == target_n);
					if (at_target) begin
						scan_lvl_n  = 1'b1;
						zone_n      = sgms_pkg::Z_GAP;
						leg_start_n = pos_s1;
					end
				end
				sgms_pkg::Z_GAP: begin
					target_n  = leg_start_q + {{(sgms_pkg::PosW-sgms_pkg::LenW){1'b0}},
						gap_length_q};
					at_target = (pos_s1 == target_n);
					if (at_target) begin
						scan_lvl_n  = 1'b0;
						zone_n      = sgms_pkg::Z_SCAN;
						leg_start_n = pos_s1;
					end
				end
				default: begin
					// return home with scanners on for the first ticks
					target_n   = home_pos_n;
					at_target  = (pos_s1 == home_pos_n);
					scan_lvl_n = (ret_ticks_q < return_scan_ticks_q);
					if (ret_ticks_q != sgms_pkg::TickMax) begin
						ret_ticks_n = ret_ticks_q + 1'b1;
					end
					if (at_target) begin
						run_n       = 1'b0;
						ret_ticks_n = '0;
						zone_n      = sgms_pkg::Z_FIRST;
					end
				end
			endcase
		end

		zone_out_n = active ? zone_eff : zone_q;
	end

	// update sequencer state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homed_q     <= 1'b0;
			run_q       <= 1'b0;
			home_pos_q  <= '0;
			leg_start_q <= '0;
			zone_q      <= sgms_pkg::Z_FIRST;
			ret_ticks_q <= '0;
			scan_lvl_q  <= 1'b0;
		end else if (advance) begin
			homed_q     <= homed_n;
			run_q       <= run_n;
			home_pos_q  <= home_pos_n;
			leg_start_q <= leg_start_n;
			zone_q      <= zone_n;
			ret_ticks_q <= ret_ticks_n;
			scan_lvl_q  <= scan_lvl_n;
		end
	end

	// output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q      <= cmd_n;
			target_q   <= target_n;
			scan_en_q  <= scan_lvl_n;
			zone_out_q <= zone_out_n;
		end
	end

	assign out_valid       = out_v_q;
	assign motor_command   = cmd_q;
	assign target_position = signed'(target_q);
	assign scanner_enable  = scan_en_q;
	assign zone            = zone_out_q;

	// home, once found, is never lost
	a_homed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		homed_q |=> homed_q)
		else $error("homed flag dropped");

	// outside a run the zone rests at travel to first tube
	a_idle_zone: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> zone_q == sgms_pkg::Z_FIRST)
		else $error("zone moved without an active run");

	// a target is only reported with a move command
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && cmd_q != sgms_pkg::CMD_MOVE |-> target_q == '0)
		else $error("nonzero target without move");

	// a pending jog result means home has not been latched
	a_jog_unhomed: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && cmd_q == sgms_pkg::CMD_JOG |-> !homed_q)
		else $error("jog issued after homing");

	// a move command implies home has been latched
	a_move_homed: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && cmd_q == sgms_pkg::CMD_MOVE |-> homed_q)
		else $error("move issued before homing");

endmodule
